// ===== design/fbc_pkg.sv =====
package fbc_pkg;

    localparam int NUM_PLANES = 6;

    localparam int PIDX_W  = 3;
    localparam int NORM_W  = 18;
    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = NORM_W + COORD_W;
    localparam int OFF_W   = COORD_W + FRAC_W;
    localparam int DIST_W  = 53;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TEST  = 1'b1;

    typedef struct packed {
        logic signed [NORM_W-1:0]  normal_z;
        logic signed [NORM_W-1:0]  normal_y;
        logic signed [NORM_W-1:0]  normal_x;
        logic signed [COORD_W-1:0] offset;
    } t_plane;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } t_box;

endpackage

// ===== design/fbc_in_if.sv =====
interface fbc_in_if;
    import fbc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [PIDX_W-1:0]         plane_index;
    logic signed [NORM_W-1:0]  normal_x;
    logic signed [NORM_W-1:0]  normal_y;
    logic signed [NORM_W-1:0]  normal_z;
    logic signed [COORD_W-1:0] plane_offset;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;

    modport source (
        output valid, cmd, plane_index, normal_x, normal_y, normal_z, plane_offset,
               min_x, min_y, min_z, max_x, max_y, max_z,
        input  ready
    );

    modport sink (
        input  valid, cmd, plane_index, normal_x, normal_y, normal_z, plane_offset,
               min_x, min_y, min_z, max_x, max_y, max_z,
        output ready
    );

endinterface

// ===== design/fbc_out_if.sv =====
interface fbc_out_if;

    logic valid;
    logic ready;
    logic outside;

    modport source (
        output valid, outside,
        input  ready
    );

    modport sink (
        input  valid, outside,
        output ready
    );

endinterface

// ===== design/frustum_box_cull_top.sv =====
// Channel   Role    Payload
// i_in      sink    cmd, plane_index, normal_x/y/z, plane_offset, min_x/y/z, max_x/y/z
// o_out     source  outside
//
// One item per cycle while o_out is ready; a result is offered once it has passed the input
// register at the transfer, then the product register, then the result register.
// The six products of each plane lane set the second stage; all lanes run side by side.
// A plane write lands in the table at its input transfer, so any later test sees it.
// Synchronous reset clears the plane table and empties the pipeline.
// A stall on o_out holds each full stage; empty stages still fill, so up to three
// items wait before i_in.ready drops.
module frustum_box_cull_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fbc_in_if.sink     i_in,
    fbc_out_if.source  o_out
);
    import fbc_pkg::*;

    logic   w_en1;
    logic   w_en2;
    logic   w_en3;
    logic   w_accept;
    logic   w_we;
    t_plane w_wr_plane;
    t_plane w_planes [NUM_PLANES];
    logic [NUM_PLANES-1:0] w_behind;

    logic   r_s1_valid;
    logic   r_s1_test;
    t_box   r_s1_box;
    logic   r_s2_valid;
    logic   r_s2_test;
    logic   r_out_valid;
    logic   r_outside;
    logic   n_outside;

    // each stage advances when the one after it is empty or advancing
    assign w_en3    = !r_out_valid || o_out.ready;
    assign w_en2    = !r_s2_valid || w_en3;
    assign w_en1    = !r_s1_valid || w_en2;
    assign i_in.ready = w_en1;
    assign w_accept = i_in.valid && w_en1;
    assign w_we     = w_accept && (i_in.cmd == CMD_WRITE);

    assign w_wr_plane.normal_x = i_in.normal_x;
    assign w_wr_plane.normal_y = i_in.normal_y;
    assign w_wr_plane.normal_z = i_in.normal_z;
    assign w_wr_plane.offset   = i_in.plane_offset;

    fbc_plane_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (w_we),
        .i_index  (i_in.plane_index),
        .i_plane  (w_wr_plane),
        .o_planes (w_planes)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en1) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_test      <= (i_in.cmd == CMD_TEST);
            r_s1_box.min_x <= i_in.min_x;
            r_s1_box.min_y <= i_in.min_y;
            r_s1_box.min_z <= i_in.min_z;
            r_s1_box.max_x <= i_in.max_x;
            r_s1_box.max_y <= i_in.max_y;
            r_s1_box.max_z <= i_in.max_z;
        end
    end

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
        fbc_plane_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (w_en2),
            .i_plane  (w_planes[p]),
            .i_box    (r_s1_box),
            .o_behind (w_behind[p])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_test <= r_s1_test;
        end
    end

    // writes report inside
    assign n_outside = r_s2_test && (|w_behind);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en3) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_outside <= n_outside;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.outside = r_outside;

`ifndef SYNTHESIS
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || o_out.ready) |-> i_in.ready)
        else $error("input stalled while the result register is free");

    a_write_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en3 && r_s2_valid && !r_s2_test) |=> (o_out.valid && !o_out.outside))
        else $error("plane write produced an outside result");

    a_stall_holds_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_en2) |=> r_s1_valid)
        else $error("stalled first-stage item dropped");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out.valid && !r_s1_valid && !r_s2_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule

// ===== design/fbc_plane_table.sv =====
module fbc_plane_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_we,
    input  logic [fbc_pkg::PIDX_W-1:0]   i_index,
    input  fbc_pkg::t_plane              i_plane,
    output fbc_pkg::t_plane              o_planes [fbc_pkg::NUM_PLANES]
);
    import fbc_pkg::*;

    t_plane r_planes [NUM_PLANES];

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_entry
        logic w_hit;

        // writes to an index beyond the table hit no entry and are dropped
        assign w_hit = i_we && ({1'b0, i_index} == (PIDX_W + 1)'(p));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_planes[p] <= '0;
            end else if (w_hit) begin
                r_planes[p] <= i_plane;
            end
        end

        assign o_planes[p] = r_planes[p];
    end

endmodule

// ===== design/fbc_plane_lane.sv =====
module fbc_plane_lane (
    input  logic            i_clk,
    input  logic            i_en,
    input  fbc_pkg::t_plane i_plane,
    input  fbc_pkg::t_box   i_box,
    output logic            o_behind
);
    import fbc_pkg::*;

    logic signed [NORM_W-1:0]  w_norm   [3];
    logic signed [COORD_W-1:0] w_lo     [3];
    logic signed [COORD_W-1:0] w_hi     [3];
    logic signed [COORD_W-1:0] w_far_c  [3];
    logic signed [COORD_W-1:0] w_near_c [3];
    logic signed [PROD_W-1:0]  n_far_p  [3];
    logic signed [PROD_W-1:0]  n_near_p [3];
    logic signed [PROD_W-1:0]  r_far_p  [3];
    logic signed [PROD_W-1:0]  r_near_p [3];
    logic signed [OFF_W-1:0]   n_off;
    logic signed [OFF_W-1:0]   r_off;
    logic signed [DIST_W-1:0]  w_far_d;
    logic signed [DIST_W-1:0]  w_near_d;

    assign w_norm[0] = i_plane.normal_x;
    assign w_norm[1] = i_plane.normal_y;
    assign w_norm[2] = i_plane.normal_z;
    assign w_lo[0]   = i_box.min_x;
    assign w_lo[1]   = i_box.min_y;
    assign w_lo[2]   = i_box.min_z;
    assign w_hi[0]   = i_box.max_x;
    assign w_hi[1]   = i_box.max_y;
    assign w_hi[2]   = i_box.max_z;

    // a negative normal component swaps which bound lies farther along the normal
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_far_c[k]  = w_norm[k][NORM_W-1] ? w_lo[k] : w_hi[k];
            w_near_c[k] = w_norm[k][NORM_W-1] ? w_hi[k] : w_lo[k];
            n_far_p[k]  = w_norm[k] * w_far_c[k];
            n_near_p[k] = w_norm[k] * w_near_c[k];
        end
    end

    // align the Q16.16 offset to the 32 fraction bits of the products
    assign n_off = $signed({i_plane.offset, {FRAC_W{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_far_p  <= n_far_p;
            r_near_p <= n_near_p;
            r_off    <= n_off;
        end
    end

    assign w_far_d  = DIST_W'(r_off) + DIST_W'(r_far_p[0]) + DIST_W'(r_far_p[1])
                    + DIST_W'(r_far_p[2]);
    assign w_near_d = DIST_W'(r_off) + DIST_W'(r_near_p[0]) + DIST_W'(r_near_p[1])
                    + DIST_W'(r_near_p[2]);

    assign o_behind = w_far_d[DIST_W-1] & w_near_d[DIST_W-1];

endmodule

// ===== dv/fbc_cull_checker.sv =====
`timescale 1ns / 100ps

module fbc_cull_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    fbc_in_if    i_in,
    fbc_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);
    import fbc_pkg::*;

    localparam int REPORT_LIMIT = 10;

    t_plane plane_tbl [NUM_PLANES];
    logic   outside_expected_q [$];
    int     fail_count = 0;

    function automatic void report_error(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endfunction

    // A box is culled when both its near and far corner lie behind some plane.
    function automatic logic box_is_culled(input t_box b);
        longint lo [3];
        longint hi [3];
        longint nrm [3];
        longint near_d;
        longint far_d;
        logic   culled;
        culled = 1'b0;
        lo[0] = longint'(b.min_x);
        lo[1] = longint'(b.min_y);
        lo[2] = longint'(b.min_z);
        hi[0] = longint'(b.max_x);
        hi[1] = longint'(b.max_y);
        hi[2] = longint'(b.max_z);
        for (int p = 0; p < NUM_PLANES; p++) begin
            nrm[0] = longint'(plane_tbl[p].normal_x);
            nrm[1] = longint'(plane_tbl[p].normal_y);
            nrm[2] = longint'(plane_tbl[p].normal_z);
            // align the Q16.16 offset to the 32 fraction bits of the products
            far_d  = longint'(plane_tbl[p].offset) * (longint'(1) << FRAC_W);
            near_d = far_d;
            for (int k = 0; k < 3; k++) begin
                if (nrm[k] < 0) begin
                    far_d  += nrm[k] * lo[k];
                    near_d += nrm[k] * hi[k];
                end else begin
                    far_d  += nrm[k] * hi[k];
                    near_d += nrm[k] * lo[k];
                end
            end
            if (far_d < 0 && near_d < 0) begin
                culled = 1'b1;
            end
        end
        return culled;
    endfunction

    always @(posedge i_clk) begin : watch
        logic expected;
        if (!i_rst_n) begin
            foreach (plane_tbl[p]) begin
                plane_tbl[p] = '0;
            end
            outside_expected_q.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (outside_expected_q.size() == 0) begin
                    report_error($sformatf("result with no pending transfer: outside=%0b",
                                           i_out.outside));
                end else begin
                    expected = outside_expected_q.pop_front();
                    if (i_out.outside !== expected) begin
                        report_error($sformatf("outside mismatch: expected %0b, actual %0b",
                                               expected, i_out.outside));
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.cmd == CMD_WRITE) begin
                    // drop writes past the end of the table
                    if (i_in.plane_index < NUM_PLANES) begin
                        plane_tbl[i_in.plane_index] = '{normal_z: i_in.normal_z,
                                                        normal_y: i_in.normal_y,
                                                        normal_x: i_in.normal_x,
                                                        offset:   i_in.plane_offset};
                    end
                    outside_expected_q.push_back(1'b0);
                end else begin
                    outside_expected_q.push_back(box_is_culled('{min_x: i_in.min_x,
                                                                 min_y: i_in.min_y,
                                                                 min_z: i_in.min_z,
                                                                 max_x: i_in.max_x,
                                                                 max_y: i_in.max_y,
                                                                 max_z: i_in.max_z}));
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= outside_expected_q.size();
    end

endmodule

// ===== dv/tb_frustum_box_cull_top.sv =====
`timescale 1ns / 100ps

module tb_frustum_box_cull_top;
    import fbc_pkg::*;

    localparam int ITEM_COUNT     = 1400;
    localparam int HOLD_CYCLES    = 300;
    localparam int BURST_ITEMS    = 40;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TIMEOUT_CYCLES = 800000;
    localparam int NORM_ONE       = 1 << FRAC_W;

    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [NORM_W-1:0]  NORM_MIN  = {1'b1, {(NORM_W-1){1'b0}}};
    localparam logic signed [NORM_W-1:0]  NORM_MAX  = {1'b0, {(NORM_W-1){1'b1}}};

    typedef struct packed {
        logic              cmd;
        logic [PIDX_W-1:0] plane_index;
        t_plane            plane;
        t_box              box;
    } t_cull_item;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   steady_phase;
    bit   hold_off_req;
    int   fail_count;
    int   pending_results;
    int   cycle_count = 0;

    fbc_in_if  in_ch ();
    fbc_out_if out_ch ();

    frustum_box_cull_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    fbc_cull_checker u_cull_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES) begin
            $display("tb_frustum_box_cull_top failed");
            $finish;
        end
    end

    // mostly back to back, sometimes a short gap, rarely a long gap
    function automatic int idle_len();
        int r;
        if (steady_phase) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [COORD_W-1:0] q16(input int whole);
        return whole <<< FRAC_W;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? COORD_MIN : COORD_MAX;
            default: return int'($urandom_range(0, 400 << FRAC_W)) - (200 << FRAC_W);
        endcase
    endfunction

    function automatic logic signed [NORM_W-1:0] rand_normal();
        int v;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return NORM_W'($urandom);
            2: return $urandom_range(0, 1) ? NORM_MIN : NORM_MAX;
            default: begin
                v = $urandom_range(0, 2 * NORM_ONE - 1);
                return $urandom_range(0, 1) ? NORM_W'(-v) : NORM_W'(v);
            end
        endcase
    endfunction

    // one axis of a box: mostly ordered, sometimes inverted or unrelated bounds
    function automatic void rand_span(output logic signed [COORD_W-1:0] lo,
                                      output logic signed [COORD_W-1:0] hi);
        lo = rand_coord();
        case ($urandom_range(0, 9))
            0, 1:    hi = rand_coord();
            2:       hi = lo - $urandom_range(0, 20 << FRAC_W);
            default: hi = lo + $urandom_range(0, 60 << FRAC_W);
        endcase
    endfunction

    function automatic t_cull_item plane_write(input int idx,
                                               input logic signed [NORM_W-1:0] nx,
                                               input logic signed [NORM_W-1:0] ny,
                                               input logic signed [NORM_W-1:0] nz,
                                               input logic signed [COORD_W-1:0] off);
        t_cull_item it;
        it.cmd         = CMD_WRITE;
        it.plane_index = idx[PIDX_W-1:0];
        it.plane       = '{normal_z: nz, normal_y: ny, normal_x: nx, offset: off};
        it.box         = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return it;
    endfunction

    function automatic t_cull_item box_test(input logic signed [COORD_W-1:0] lx,
                                            input logic signed [COORD_W-1:0] ly,
                                            input logic signed [COORD_W-1:0] lz,
                                            input logic signed [COORD_W-1:0] hx,
                                            input logic signed [COORD_W-1:0] hy,
                                            input logic signed [COORD_W-1:0] hz);
        t_cull_item it;
        it.cmd         = CMD_TEST;
        it.plane_index = PIDX_W'($urandom_range(0, 2**PIDX_W - 1));
        it.plane       = {$urandom, $urandom, 22'($urandom)};
        it.box         = '{min_x: lx, min_y: ly, min_z: lz, max_x: hx, max_y: hy, max_z: hz};
        return it;
    endfunction

    task automatic drive_fields(input t_cull_item it);
        in_ch.cmd          <= it.cmd;
        in_ch.plane_index  <= it.plane_index;
        in_ch.normal_x     <= it.plane.normal_x;
        in_ch.normal_y     <= it.plane.normal_y;
        in_ch.normal_z     <= it.plane.normal_z;
        in_ch.plane_offset <= it.plane.offset;
        in_ch.min_x        <= it.box.min_x;
        in_ch.min_y        <= it.box.min_y;
        in_ch.min_z        <= it.box.min_z;
        in_ch.max_x        <= it.box.max_x;
        in_ch.max_y        <= it.box.max_y;
        in_ch.max_z        <= it.box.max_z;
    endtask

    task automatic offer_item(input t_cull_item it, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : idle_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        drive_fields(it);
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        int stall_left;
        bit hold_done;
        hold_left  = 0;
        stall_left = 0;
        hold_done  = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                stall_left = idle_len();
            end
        end
    end

    initial begin
        t_cull_item blank;
        int         burst_left;
        blank        = '0;
        burst_left   = 0;
        hold_off_req = 1'b0;
        steady_phase = 1'b0;
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        drive_fields(blank);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table never culls
        offer_item(box_test(q16(-1), q16(-1), q16(-1), q16(1), q16(1), q16(1)), 1'b0);
        offer_item(box_test(COORD_MIN, COORD_MIN, COORD_MIN,
                            COORD_MAX, COORD_MAX, COORD_MAX), 1'b0);
        offer_item(plane_write(0, NORM_ONE, 0, 0, 0), 1'b0);
        offer_item(box_test(q16(-10), 0, 0, q16(-5), q16(1), q16(1)), 1'b0);
        offer_item(box_test(q16(-10), 0, 0, q16(5), q16(1), q16(1)), 1'b0);
        // inverted boxes
        offer_item(box_test(q16(-5), 0, 0, q16(-10), q16(1), q16(1)), 1'b0);
        offer_item(box_test(q16(5), 0, 0, q16(-10), q16(1), q16(1)), 1'b0);
        offer_item(plane_write(1, NORM_MIN, NORM_MAX, 0, COORD_MAX), 1'b0);
        // writes past the table end must leave it alone
        offer_item(plane_write(NUM_PLANES, NORM_ONE, NORM_ONE, NORM_ONE, COORD_MIN), 1'b0);
        offer_item(plane_write(NUM_PLANES + 1, NORM_MIN, NORM_MIN, NORM_MIN, COORD_MIN), 1'b0);
        offer_item(box_test(COORD_MIN, COORD_MIN, COORD_MIN,
                            COORD_MAX, COORD_MAX, COORD_MAX), 1'b0);
        offer_item(box_test(COORD_MIN, COORD_MIN, COORD_MIN,
                            COORD_MIN, COORD_MIN, COORD_MIN), 1'b0);
        offer_item(box_test(COORD_MAX, COORD_MAX, COORD_MAX,
                            COORD_MAX, COORD_MAX, COORD_MAX), 1'b0);
        // zero normal with negative offset culls everything
        offer_item(plane_write(2, 0, 0, 0, -1), 1'b0);
        offer_item(box_test(q16(1), q16(1), q16(1), q16(2), q16(2), q16(2)), 1'b0);
        offer_item(plane_write(2, 0, -NORM_ONE, 0, 0), 1'b0);
        offer_item(box_test(0, q16(1), 0, q16(1), q16(2), q16(1)), 1'b0);
        offer_item(box_test(0, q16(-2), 0, q16(1), q16(-1), q16(1)), 1'b0);
        offer_item(plane_write(0, 0, 0, 0, 0), 1'b0);
        offer_item(plane_write(1, 0, 0, 0, 0), 1'b0);
        offer_item(plane_write(2, 0, 0, 0, 0), 1'b0);
        offer_item(box_test(COORD_MIN, COORD_MIN, COORD_MIN,
                            COORD_MIN, COORD_MIN, COORD_MIN), 1'b0);
        wait_drained();

        for (int n = 0; n < ITEM_COUNT; n++) begin
            t_cull_item                it;
            logic signed [COORD_W-1:0] lx, ly, lz, hx, hy, hz;
            logic signed [COORD_W-1:0] off;
            int                        idx;
            if (n % 200 == 0) begin
                steady_phase = (n == 400) || ($urandom_range(0, 3) == 0);
            end
            // stall the output while the input keeps offering, to back up the pipe
            if (n == 700) begin
                hold_off_req = 1'b1;
                burst_left   = BURST_ITEMS;
            end
            if (n % 350 == 349) begin
                wait_drained();
            end
            if ($urandom_range(0, 3) == 0) begin
                idx = ($urandom_range(0, 9) == 0) ? $urandom_range(NUM_PLANES, 2**PIDX_W - 1)
                                                  : $urandom_range(0, NUM_PLANES - 1);
                // keep offsets mostly positive so that boxes survive often enough
                off = ($urandom_range(0, 4) == 0) ? rand_coord()
                    : int'($urandom_range(0, 400 << FRAC_W)) - (50 << FRAC_W);
                if ($urandom_range(0, 6) == 0) begin
                    it = plane_write(idx, 0, 0, 0, 0);
                end else begin
                    it = plane_write(idx, rand_normal(), rand_normal(), rand_normal(), off);
                end
            end else begin
                rand_span(lx, hx);
                rand_span(ly, hy);
                rand_span(lz, hz);
                it = box_test(lx, ly, lz, hx, hy, hz);
            end
            offer_item(it, burst_left > 0);
            if (burst_left > 0) begin
                burst_left--;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("tb_frustum_box_cull_top passed");
        end else begin
            $display("tb_frustum_box_cull_top failed");
        end
        $finish;
    end

endmodule
